// ===== hw/rtl/fss_pkg.sv =====
// Shared package for the follow slot select block.
// Holds the action codes, hash constants, pipeline depths and the control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    // Follow action codes
    typedef enum logic [2:0] {
        MODE_NONE     = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_AGAIN    = 3'd2,
        MODE_NEXT     = 3'd3,
        MODE_PREVIOUS = 3'd4,
        MODE_RANDOM   = 3'd5
    } t_mode;

    // Default upper bound on the slot count
    localparam int MAX_SLOTS_DEF = 256;

    // Result field width
    localparam int TGT_W = 8;

    // splitmix64 finalizer constants
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;
    localparam logic [31:0] MIX1_LO = MIX1[31:0];
    localparam logic [31:0] MIX1_HI = MIX1[63:32];
    localparam logic [31:0] MIX2_LO = MIX2[31:0];
    localparam logic [31:0] MIX2_HI = MIX2[63:32];
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    // Pipeline depths
    localparam int FIN_STAGES = 5;   // stages per finalizer
    localparam int MOD_STEPS  = 8;   // remainder bits resolved per stage
    localparam int HASH_W     = 64;

    // Decision carried alongside the hash
    typedef struct packed {
        logic             go;
        logic             is_rand;
        logic [TGT_W-1:0] target;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/fss_finalizer.sv =====
// One splitmix64 finalizer, pipelined over five register stages.
// Constant multiplies are split into 32-bit partial products and summed a stage later.
// Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fss_finalizer #(
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [63:0]     i_data,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [63:0]     o_data,
    output logic [SB_W-1:0] o_sb
);
    import fss_pkg::*;

    logic [FIN_STAGES-1:0] r_vld;
    logic [FIN_STAGES-1:0] n_vld_in;
    logic [FIN_STAGES:0]   en;
    logic [SB_W-1:0]       r_sb [FIN_STAGES];

    logic [63:0] v;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] r_a,  n_a;
    logic [63:0] r_p0, n_p0;
    logic [31:0] r_p1, n_p1;
    logic [31:0] r_p2, n_p2;
    logic [63:0] r_b,  n_b;
    logic [63:0] r_q0, n_q0;
    logic [31:0] r_q1, n_q1;
    logic [31:0] r_q2, n_q2;
    logic [63:0] r_h,  n_h;

    // A stage loads when it is empty or its successor moves
    assign en[FIN_STAGES] = !i_stall;
    for (genvar k = 0; k < FIN_STAGES; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    assign n_vld_in = {r_vld[FIN_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < FIN_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld_in[k];
                end
            end
        end
    end

    always_comb begin
        v    = i_data + GOLDEN;
        n_a  = v ^ (v >> SHIFT_A);
        n_p0 = 64'(r_a[31:0]) * 64'(MIX1_LO);
        n_p1 = r_a[63:32] * MIX1_LO;
        n_p2 = r_a[31:0] * MIX1_HI;
        m1   = r_p0 + {r_p1 + r_p2, 32'd0};
        n_b  = m1 ^ (m1 >> SHIFT_B);
        n_q0 = 64'(r_b[31:0]) * 64'(MIX2_LO);
        n_q1 = r_b[63:32] * MIX2_LO;
        n_q2 = r_b[31:0] * MIX2_HI;
        m2   = r_q0 + {r_q1 + r_q2, 32'd0};
        n_h  = m2 ^ (m2 >> SHIFT_C);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a     <= n_a;
            r_sb[0] <= i_sb;
        end
        if (en[1]) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
        if (en[2]) begin
            r_b <= n_b;
        end
        if (en[3]) begin
            r_q0 <= n_q0;
            r_q1 <= n_q1;
            r_q2 <= n_q2;
        end
        if (en[4]) begin
            r_h <= n_h;
        end
        for (int k = 1; k < FIN_STAGES; k++) begin
            if (en[k]) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[FIN_STAGES-1];
    assign o_data  = r_h;
    assign o_sb    = r_sb[FIN_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/fss_mod_unit.sv =====
// Pipelined restoring remainder of a 64-bit hash by the slot count.
// Each stage resolves MOD_STEPS dividend bits, most significant first.
// Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fss_mod_unit #(
    parameter int CNT_W = 9,
    parameter int SB_W  = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [63:0]        i_dividend,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [SB_W-1:0]    i_sb,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CNT_W-1:0]   o_rem,
    output logic [CNT_W-1:0]   o_count,
    output logic [SB_W-1:0]    o_sb
);
    import fss_pkg::*;

    localparam int NS = HASH_W / MOD_STEPS;

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      n_vld_in;
    logic [NS:0]        en;
    logic [CNT_W-1:0]   r_rem [NS];
    logic [CNT_W-1:0]   n_rem [NS];
    logic [CNT_W-1:0]   r_cnt [NS];
    logic [CNT_W-1:0]   cnt_in [NS];
    logic [63:0]        r_dvd [NS];
    logic [63:0]        dvd_in [NS];
    logic [SB_W-1:0]    r_sb [NS];
    logic [SB_W-1:0]    sb_in [NS];

    assign en[NS] = !i_stall;
    assign n_vld_in = {r_vld[NS-2:0], i_valid};

    for (genvar k = 0; k < NS; k++) begin : g_stg
        logic [CNT_W-1:0] rem_in;
        logic [CNT_W-1:0] rem;
        logic [CNT_W:0]   trial;

        assign en[k] = !r_vld[k] || en[k+1];

        if (k == 0) begin : g_first
            assign rem_in    = '0;
            assign dvd_in[k] = i_dividend;
            assign cnt_in[k] = i_count;
            assign sb_in[k]  = i_sb;
        end else begin : g_next
            assign rem_in    = r_rem[k-1];
            assign dvd_in[k] = r_dvd[k-1];
            assign cnt_in[k] = r_cnt[k-1];
            assign sb_in[k]  = r_sb[k-1];
        end

        // Shift in one dividend bit, subtract the count when it fits
        always_comb begin
            rem   = rem_in;
            trial = '0;
            for (int s = 0; s < MOD_STEPS; s++) begin
                trial = {rem, dvd_in[k][HASH_W-1-s]};
                if (trial >= {1'b0, cnt_in[k]}) begin
                    rem = CNT_W'(trial - {1'b0, cnt_in[k]});
                end else begin
                    rem = trial[CNT_W-1:0];
                end
            end
        end

        assign n_rem[k] = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= dvd_in[k] << MOD_STEPS;
                r_cnt[k] <= cnt_in[k];
                r_sb[k]  <= sb_in[k];
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];
    assign o_rem   = r_rem[NS-1];
    assign o_count = r_cnt[NS-1];
    assign o_sb    = r_sb[NS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/follow_slot_select_core.sv =====
// Follow slot select: decides which slot of a track a follow action starts.
// Top level; instantiates three fss_finalizer stages and fss_mod_unit, uses fss_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one request transaction: the follow
//   action, track id, scene number, raw due-beat bits, the requester's position,
//   the slot count and a found flag. Output channel (o_valid / i_stall) returns
//   one transaction per request: o_start_target and o_target_position.
//   Transactions are accepted when valid is high and stall is low.
//
// Timing:
//   The block is a 24-register pipeline: 15 stages for the three chained
//   splitmix64 finalizers (5 each), 8 stages for the remainder by the slot count
//   (8 quotient bits per stage) and one output register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   every request walks the full pipeline so results leave in request order.
//
// Reset and backpressure:
//   Synchronous active-low reset empties the pipeline; no other state exists.
//   When the receiver stalls, the result holds in the output register and
//   upstream stages keep filling their empty slots; o_stall rises only when
//   every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module follow_slot_select_core #(
    parameter int MAX_SLOTS = fss_pkg::MAX_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_mode,
    input  logic [31:0]             i_track_id,
    input  logic [31:0]             i_scene_number,
    input  logic [63:0]             i_due_beat_bits,
    input  logic [7:0]              i_self_position,
    input  logic [8:0]              i_slot_count,
    input  logic                    i_self_found,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_start_target,
    output logic [fss_pkg::TGT_W-1:0] o_target_position
);
    import fss_pkg::*;

    // Clamped count width: the port carries at most 9 bits
    localparam int CNT_W  = (MAX_SLOTS >= 511) ? 9 : $clog2(MAX_SLOTS + 1);
    localparam int CTL_W  = $bits(t_ctl);
    localparam int SB1_W  = 32 + 64 + CTL_W + CNT_W;
    localparam int SB2_W  = 64 + CTL_W + CNT_W;
    localparam int SB3_W  = CTL_W + CNT_W;

    // ---------------------------------------------------------------
    // Decode: everything except the random pick is settled here and
    // rides along with the hash.
    // ---------------------------------------------------------------
    logic [8:0]       cnt_clamp;
    logic [CNT_W-1:0] cnt;
    logic             found;
    logic [8:0]       pos_ext;
    t_ctl             ctl;

    always_comb begin
        cnt_clamp = (32'(i_slot_count) > MAX_SLOTS) ? 9'(MAX_SLOTS) : i_slot_count;
        cnt       = CNT_W'(cnt_clamp);
        pos_ext   = {1'b0, i_self_position};
        // A position outside the count is treated as not found
        found     = i_self_found && (pos_ext < cnt_clamp);
        ctl       = '0;
        if (found) begin
            unique case (t_mode'(i_mode))
                MODE_AGAIN: begin
                    ctl.go     = 1'b1;
                    ctl.target = i_self_position;
                end
                MODE_NEXT: begin
                    // no wrap past the last slot
                    if ((pos_ext + 9'd1) < cnt_clamp) begin
                        ctl.go     = 1'b1;
                        ctl.target = i_self_position + 8'd1;
                    end
                end
                MODE_PREVIOUS: begin
                    // stop at the first slot
                    if (i_self_position != 8'd0) begin
                        ctl.go     = 1'b1;
                        ctl.target = i_self_position - 8'd1;
                    end
                end
                MODE_RANDOM: begin
                    ctl.go      = 1'b1;
                    ctl.is_rand = 1'b1;
                end
                default: begin
                    ctl = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Hash chain: track, then scene, then beat.
    // ---------------------------------------------------------------
    logic               f1_valid, f1_stall;
    logic [63:0]        f1_h;
    logic [SB1_W-1:0]   f1_sb;
    logic               f2_valid, f2_stall;
    logic [63:0]        f2_h;
    logic [SB2_W-1:0]   f2_sb;
    logic               f3_valid, f3_stall;
    logic [63:0]        f3_h;
    logic [SB3_W-1:0]   f3_sb;
    logic [31:0]        f1_scene;
    logic [SB2_W-1:0]   f1_rest;
    logic [63:0]        f2_beat;
    logic [SB3_W-1:0]   f2_rest;

    fss_finalizer #(.SB_W(SB1_W)) u_fin_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  ({32'd0, i_track_id}),
        .i_sb    ({i_scene_number, i_due_beat_bits, ctl, cnt}),
        .o_valid (f1_valid),
        .i_stall (f1_stall),
        .o_data  (f1_h),
        .o_sb    (f1_sb)
    );

    assign {f1_scene, f1_rest} = f1_sb;

    fss_finalizer #(.SB_W(SB2_W)) u_fin_scene (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f1_valid),
        .o_stall (f1_stall),
        .i_data  (f1_h ^ {32'd0, f1_scene}),
        .i_sb    (f1_rest),
        .o_valid (f2_valid),
        .i_stall (f2_stall),
        .o_data  (f2_h),
        .o_sb    (f2_sb)
    );

    assign {f2_beat, f2_rest} = f2_sb;

    fss_finalizer #(.SB_W(SB3_W)) u_fin_beat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f2_valid),
        .o_stall (f2_stall),
        .i_data  (f2_h ^ f2_beat),
        .i_sb    (f2_rest),
        .o_valid (f3_valid),
        .i_stall (f3_stall),
        .o_data  (f3_h),
        .o_sb    (f3_sb)
    );

    // ---------------------------------------------------------------
    // Remainder by the clamped count
    // ---------------------------------------------------------------
    logic               md_valid, md_stall;
    logic [CNT_W-1:0]   md_rem;
    logic [CNT_W-1:0]   md_count;
    logic [CTL_W-1:0]   md_sb;
    t_ctl               md_ctl;

    fss_mod_unit #(.CNT_W(CNT_W), .SB_W(CTL_W)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f3_valid),
        .o_stall    (f3_stall),
        .i_dividend (f3_h),
        .i_count    (f3_sb[CNT_W-1:0]),
        .i_sb       (f3_sb[SB3_W-1 -: CTL_W]),
        .o_valid    (md_valid),
        .i_stall    (md_stall),
        .o_rem      (md_rem),
        .o_count    (md_count),
        .o_sb       (md_sb)
    );

    assign md_ctl = t_ctl'(md_sb);

    // ---------------------------------------------------------------
    // Output register: hold while the receiver stalls
    // ---------------------------------------------------------------
    logic             r_out_valid;
    logic             r_start;
    logic [TGT_W-1:0] r_target;
    logic             n_start;
    logic [TGT_W-1:0] n_target;
    logic             out_en;

    assign out_en   = !r_out_valid || !i_stall;
    assign md_stall = !out_en;

    always_comb begin
        n_start  = md_ctl.go;
        n_target = md_ctl.is_rand ? TGT_W'(md_rem) : md_ctl.target;
        // drive zero when nothing starts
        if (!md_ctl.go) begin
            n_target = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= md_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_start  <= n_start;
            r_target <= n_target;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_start_target    = r_start;
    assign o_target_position = r_target;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // The target is zero whenever no slot starts
    a_no_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_start_target) |-> (o_target_position == '0))
        else $error("target nonzero without a start");

    // A random pick is always below its count
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (md_valid && md_ctl.is_rand) |-> (md_rem < md_count))
        else $error("remainder not below slot count");

    // Input backpressure only when the output holds a stalled result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && md_valid))
        else $error("input stalled with room in the pipeline");

    // A random transaction always starts a slot
    a_rand_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (md_valid && md_ctl.is_rand) |-> md_ctl.go)
        else $error("random pick without start");

endmodule

`default_nettype wire
